// File: design/lbs_pkg.sv
// package for the leaky bounded stack
// holds register indexes, reset values and field widths shared by all files
// no dependencies
package lbs_pkg;

    // default number of stack entries
    localparam int LBS_DEPTH = 16;

    // field widths
    localparam int DATA_W     = 32;
    localparam int POS_W      = 4;
    localparam int PERIOD_W   = 16;
    localparam int CAP_W      = 5;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEAK_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 1'd1;

    // configuration reset values
    localparam logic [PERIOD_W-1:0] LEAK_PERIOD_RST = 16'd4;
    localparam logic [CAP_W-1:0]    CAPACITY_RST    = 5'd16;

endpackage

// File: design/leaky_bounded_stack.sv
// Leaky bounded stack: a stack of signed 32-bit elements that loses its
// bottom element every leak_period operations.
//
// Input channel (in_valid / in_stall): one request is a push (mode 1, value)
// or a pop (mode 0). A push on a full stack is dropped, a pop on an empty
// stack does nothing; both still count as an operation.
// Output channel (out_valid / out_stall): after every request the stack is
// listed from top to bottom, one result per element with position and an
// is_last mark, or a single result with is_empty set when nothing is held.
// Configuration: cfg_we writes leak_period (index 0) or capacity (index 1).
//
// Timing: the request is taken in ST_IDLE, ST_FETCH then issues the first read
// of the store, and in ST_SHOW one result leaves per cycle while out_stall is
// low; the single store read port sets the pace. in_stall stays high until
// the last result is taken. When the receiver stalls the current result holds
// and the listing pauses.
// Elements sit in a circular buffer, so a leak only moves the base pointer.
// Reset empties the stack, clears the operation counter and restores
// leak_period to 4 and capacity to 16; no clearing pass is needed.
module leaky_bounded_stack #(
    parameter int DEPTH = lbs_pkg::LBS_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          cfg_we,
    input  logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lbs_pkg::CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic signed [lbs_pkg::DATA_W-1:0] value,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [lbs_pkg::DATA_W-1:0] element,
    output logic [lbs_pkg::POS_W-1:0]     position,
    output logic                          is_last,
    output logic                          is_empty
);
    import lbs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHOW
    } state_t;

    state_t                state_reg, state_next;
    logic [PERIOD_W-1:0]   leak_period_reg;
    logic [CAP_W-1:0]      capacity_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [PTR_W-1:0]      base_reg, base_next;
    logic [PERIOD_W-1:0]   ctr_reg, ctr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]      pos_reg, pos_next;
    logic                  empty_reg, empty_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  in_accept;
    logic                  out_accept;
    logic [CMP_W-1:0]      cap_eff;
    logic                  has_room;
    logic [CNT_W-1:0]      cnt_after_op;
    logic [PERIOD_W-1:0]   ctr_inc;
    logic                  leak_hit;
    logic [SUM_W-1:0]      wr_sum;
    logic [SUM_W-1:0]      top_sum;
    logic [PTR_W-1:0]      top_ptr;
    logic [PTR_W-1:0]      rd_ptr_dec;
    logic                  listing_last;
    logic [PTR_W+POS_W-1:0] pos_ext;

    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
    logic [DATA_W-1:0]     rd_data;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    // effective capacity, never above the store depth
    assign cap_eff  = (CMP_W'(capacity_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                            : CMP_W'(capacity_reg);
    assign has_room = CMP_W'(count_reg) < cap_eff;

    // slot above the current top, wrapped around the buffer
    always_comb
    begin
        wr_sum = SUM_W'(base_reg) + SUM_W'(count_reg);
        if (wr_sum >= SUM_W'(DEPTH))
        begin
            wr_sum = wr_sum - SUM_W'(DEPTH);
        end
    end
    assign wr_addr = wr_sum[PTR_W-1:0];
    assign wr_en   = in_accept && mode && has_room;

    // top slot for the listing, from the updated base and count
    always_comb
    begin
        top_sum = SUM_W'(base_reg) + SUM_W'(count_reg) - SUM_W'(1);
        if (top_sum >= SUM_W'(DEPTH))
        begin
            top_sum = top_sum - SUM_W'(DEPTH);
        end
    end
    assign top_ptr = top_sum[PTR_W-1:0];

    // step down one slot with wrap
    assign rd_ptr_dec = (rd_ptr_reg == '0) ? LAST_PTR : rd_ptr_reg - PTR_W'(1);

    assign listing_last = empty_reg || (CNT_W'(pos_reg) == count_reg - CNT_W'(1));

    // stack update for one request, operation counter and leak
    always_comb
    begin
        cnt_after_op = count_reg;
        if (mode)
        begin
            if (has_room)
            begin
                cnt_after_op = count_reg + CNT_W'(1);
            end
        end
        else if (count_reg != '0)
        begin
            cnt_after_op = count_reg - CNT_W'(1);
        end
        ctr_inc  = ctr_reg + PERIOD_W'(1);
        leak_hit = (ctr_inc == leak_period_reg);
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        base_next      = base_reg;
        ctr_next       = ctr_reg;
        rd_ptr_next    = rd_ptr_reg;
        pos_next       = pos_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg;
        rd_en          = 1'b0;
        rd_addr        = rd_ptr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    count_next = cnt_after_op;
                    ctr_next   = leak_hit ? '0 : ctr_inc;
                    if (leak_hit && cnt_after_op != '0)
                    begin
                        count_next = cnt_after_op - CNT_W'(1);
                        base_next  = (base_reg == LAST_PTR) ? '0 : base_reg + PTR_W'(1);
                    end
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // read the top element, or show the empty marker
                rd_addr        = top_ptr;
                rd_en          = (count_reg != '0);
                rd_ptr_next    = top_ptr;
                pos_next       = '0;
                empty_next     = (count_reg == '0);
                out_valid_next = 1'b1;
                state_next     = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_accept)
                begin
                    if (listing_last)
                    begin
                        out_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        rd_addr     = rd_ptr_dec;
                        rd_en       = 1'b1;
                        rd_ptr_next = rd_ptr_dec;
                        pos_next    = pos_reg + PTR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            base_reg      <= '0;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
            empty_reg     <= 1'b0;
            pos_reg       <= '0;
            rd_ptr_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
            empty_reg     <= empty_next;
            pos_reg       <= pos_next;
            rd_ptr_reg    <= rd_ptr_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leak_period_reg <= LEAK_PERIOD_RST;
            capacity_reg    <= CAPACITY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEAK_PERIOD: leak_period_reg <= cfg_data[PERIOD_W-1:0];
                REG_CAPACITY:    capacity_reg    <= cfg_data[CAP_W-1:0];
                default:         ;
            endcase
        end
    end

    // element store
    lbs_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result outputs
    assign pos_ext   = {{POS_W{1'b0}}, pos_reg};
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign element   = empty_reg ? '0 : rd_data;
    assign position  = empty_reg ? '0 : pos_ext[POS_W-1:0];
    assign is_last   = listing_last;
    assign is_empty  = empty_reg;

endmodule

// File: design/lbs_ram.sv
// element store of the leaky bounded stack: one write port, one read port
// read data is registered and holds while no read is issued
// depends on lbs_pkg
module lbs_ram #(
    parameter int DEPTH  = lbs_pkg::LBS_DEPTH,
    parameter int ADDR_W = 4
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [lbs_pkg::DATA_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [lbs_pkg::DATA_W-1:0] rd_data
);
    import lbs_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
